@@ rtl/rbft_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the radar beam former trigger unit.
// No dependencies; imported by rbft_cell, rbft_div and the top level.
package rbft_pkg;

  // Default window depth (top-level parameter default)
  localparam int MAX_SAMPLES_DEF = 128;

  // Field widths
  localparam int GATE_W = 14;
  localparam int PRT_W  = 16;
  localparam int AZ_W   = 16;
  localparam int NWIN_W = 8;
  localparam int STEP_W = 16;
  localparam int RUN_W  = 8;
  localparam int SINCE_W = 12;

  // Target divider widths: numerator 2*az + step, denominator 2*step
  localparam int NUM_W = 18;
  localparam int DEN_W = 17;

  // Azimuth full circle in 0.01 deg and counter limits
  localparam logic [AZ_W:0]      AZ_FULL   = 17'd36000;
  localparam logic [RUN_W-1:0]   RUN_MAX   = 8'd255;
  localparam logic [SINCE_W-1:0] SINCE_MAX = 12'd4095;

  // Register reset values
  localparam logic [NWIN_W-1:0] WIN_SIZE_RST   = 8'd64;
  localparam logic              INDEX_AZ_RST   = 1'b1;
  localparam logic [STEP_W-1:0] AZ_STEP_RST    = 16'd100;
  localparam logic [PRT_W-1:0]  PRT_TOL_RST    = 16'd1000;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIN_SIZE  = 2'd0,
    CFG_INDEX_AZ  = 2'd1,
    CFG_AZ_STEP   = 2'd2,
    CFG_PRT_TOL   = 2'd3
  } cfg_idx_t;

  // Partial results carried down the cell chain toward cell 0
  typedef struct packed {
    logic            bad;  // some PRT in the window out of tolerance
    logic [AZ_W-1:0] a1;   // azimuth n/2 places back
    logic [AZ_W-1:0] a2;   // azimuth n/2-1 places back
  } rbft_scan_t;

endpackage

@@ rtl/rbft_cell.sv @@
`timescale 1ns / 1ps
// One window cell: holds one pulse (PRT, azimuth), shifts it on a new pulse
// and merges its own check result into the scan word passed toward cell 0.
module rbft_cell import rbft_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              shift_en,
  input  logic [PRT_W-1:0]  prt_in,
  input  logic [AZ_W-1:0]   az_in,
  output logic [PRT_W-1:0]  prt_out,
  output logic [AZ_W-1:0]   az_out,
  input  logic [PRT_W-1:0]  p0,
  input  logic [PRT_W-1:0]  prt_tol,
  input  logic [NWIN_W-1:0] n_win,
  input  logic [NWIN_W-1:0] sel_a1,
  input  logic [NWIN_W-1:0] sel_a2,
  input  logic              scan_en,
  input  logic              scan_load,
  input  rbft_scan_t        scan_in,
  output rbft_scan_t        scan_out
);

  logic [PRT_W-1:0] prt_r;
  logic [AZ_W-1:0]  az_r;
  rbft_scan_t       scan_r;
  rbft_scan_t       own;
  logic [PRT_W-1:0] diff;

  // Window storage, shifts one place per accepted pulse
  always_ff @(posedge clk) begin
    if (shift_en) begin
      prt_r <= prt_in;
      az_r  <= az_in;
    end
  end

  // This cell's contribution
  always_comb begin
    diff    = (prt_r > p0) ? (prt_r - p0) : (p0 - prt_r);
    own.bad = (CELL_IDX < int'(n_win)) && (diff > prt_tol);
    own.a1  = (CELL_IDX == int'(sel_a1)) ? az_r : '0;
    own.a2  = (CELL_IDX == int'(sel_a2)) ? az_r : '0;
  end

  // Scan word: load own result, then fold in the upstream neighbor
  always_ff @(posedge clk) begin
    if (scan_en) begin
      if (scan_load) begin
        scan_r <= own;
      end else begin
        scan_r.bad <= own.bad | scan_in.bad;
        scan_r.a1  <= own.a1 | scan_in.a1;
        scan_r.a2  <= own.a2 | scan_in.a2;
      end
    end
  end

  assign prt_out  = prt_r;
  assign az_out   = az_r;
  assign scan_out = scan_r;

endmodule

@@ rtl/rbft_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on rbft_pkg for default widths.
module rbft_div import rbft_pkg::*; #(
  parameter int N_W = NUM_W,
  parameter int D_W = DEN_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           done,
  output logic [N_W-1:0] quo
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [N_W-1:0]   num_r;
  logic [D_W-1:0]   den_r;
  logic [D_W-1:0]   rem_r;
  logic [D_W:0]     trial;
  logic             fits;

  // Shift in the next numerator bit and try a subtract
  always_comb begin
    trial = {rem_r, num_r[N_W-1]};
    fits  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(N_W);
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? D_W'(trial - {1'b0, den_r}) : trial[D_W-1:0];
        num_r <= {num_r[N_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

@@ rtl/radar_beam_former_trigger_unit.sv @@
`timescale 1ns / 1ps
// Radar beam former trigger: top level with pulse window cell chain,
// target divider and decision logic. Depends on rbft_pkg, rbft_cell, rbft_div.
//
// Usage:
//   Input channel (in_*): one beat per radar pulse carrying gate count, PRT
//   and azimuth. Output channel (out_*): one beat per pulse with the beam
//   flag in tuser and the beam azimuth in tdata (0 when no beam).
//   Config channel (cfg_*): register index plus data, always ready; write
//   only while no pulse is in flight.
//   Pulses are handled one at a time: a new pulse is taken only when the
//   sequencer is idle again. For each pulse the sequencer loads the scan
//   words, carries the PRT check and centre azimuths down the chain to
//   cell 0, starts the divide and waits on it, then multiplies, wraps and
//   decides; the result goes via the pending slot to the output register.
//   Reset clears the counters, configuration registers and handshakes; the window cells
//   are not cleared and are only read once enough pulses have been seen.
//   A stalled receiver leaves one result in the output register and one in
//   the pending slot; one more pulse is taken and then holds at the decision
//   step, blocking the input until the output drains.
module radar_beam_former_trigger_unit import rbft_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Pulse input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [13:0] gate_count, [29:14] prt_us,
                                  // [45:30] pulse_azimuth, [47:46] zero
  // Beam result
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] beam_azimuth
  output logic        out_tuser,  // [0] beam_ready
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SEEN_W = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_SCAN, S_DSTART, S_DIV, S_MUL, S_WRAP, S_DECIDE
  } state_t;

  // Configuration registers
  logic [NWIN_W-1:0] win_size_r;
  logic              index_az_r;
  logic [STEP_W-1:0] az_step_r;
  logic [PRT_W-1:0]  prt_tol_r;

  // Pulse history counters
  logic [GATE_W-1:0]  last_gate_r;
  logic [RUN_W-1:0]   run_r;
  logic [SEEN_W-1:0]  seen_r;
  logic [SINCE_W-1:0] since_r;

  // Sequencer and datapath registers
  state_t            state_r;
  logic [NWIN_W-1:0] scan_cnt_r;
  logic [AZ_W:0]     prod_r;
  logic [AZ_W-1:0]   tgt_r;
  logic              res_ready_r;
  logic [AZ_W-1:0]   res_az_r;
  logic              res_pend_r;

  // Output register
  logic              out_valid_r;
  logic              out_ready_r;
  logic [AZ_W-1:0]   out_az_r;

  // Input fields
  logic [GATE_W-1:0] in_gate;
  logic [PRT_W-1:0]  in_prt;
  logic [AZ_W-1:0]   in_az;
  logic [AZ_W-1:0]   in_az_mod;
  logic              in_acc;

  assign in_gate   = in_tdata[13:0];
  assign in_prt    = in_tdata[29:14];
  assign in_az     = in_tdata[45:30];
  assign in_az_mod = ({1'b0, in_az} >= AZ_FULL) ? AZ_W'({1'b0, in_az} - AZ_FULL) : in_az;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Effective window size and step
  logic [NWIN_W-1:0] n_win;
  logic [NWIN_W-1:0] sel_a1;
  logic [NWIN_W-1:0] sel_a2;
  logic [STEP_W-1:0] step;

  always_comb begin
    if (win_size_r < NWIN_W'(2)) begin
      n_win = NWIN_W'(2);
    end else if (int'(win_size_r) > MAX_SAMPLES) begin
      n_win = NWIN_W'(MAX_SAMPLES);
    end else begin
      n_win = win_size_r;
    end
    sel_a1 = n_win >> 1;
    sel_a2 = sel_a1 - 1'b1;
    step   = (az_step_r == '0) ? STEP_W'(1) : az_step_r;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= WIN_SIZE_RST;
      index_az_r <= INDEX_AZ_RST;
      az_step_r  <= AZ_STEP_RST;
      prt_tol_r  <= PRT_TOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WIN_SIZE:  win_size_r <= cfg_data[NWIN_W-1:0];
        CFG_INDEX_AZ:  index_az_r <= cfg_data[0];
        CFG_AZ_STEP:   az_step_r  <= cfg_data;
        CFG_PRT_TOL:   prt_tol_r  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Cell chain: cell 0 holds the newest pulse, scan flows toward cell 0
  logic [PRT_W-1:0] cell_prt [MAX_SAMPLES];
  logic [AZ_W-1:0]  cell_az  [MAX_SAMPLES];
  rbft_scan_t       cell_scan[MAX_SAMPLES];
  logic             scan_en;
  logic             scan_load;

  assign scan_en   = (state_r == S_LOAD) || (state_r == S_SCAN);
  assign scan_load = (state_r == S_LOAD);

  for (genvar k = 0; k < MAX_SAMPLES; k++) begin : g_cell
    logic [PRT_W-1:0] prt_prev;
    logic [AZ_W-1:0]  az_prev;
    rbft_scan_t       scan_next;

    if (k == 0) begin : g_head
      assign prt_prev = in_prt;
      assign az_prev  = in_az_mod;
    end else begin : g_body
      assign prt_prev = cell_prt[k-1];
      assign az_prev  = cell_az[k-1];
    end

    if (k == MAX_SAMPLES - 1) begin : g_tail
      assign scan_next = '0;
    end else begin : g_up
      assign scan_next = cell_scan[k+1];
    end

    rbft_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk       (clk),
      .shift_en  (in_acc),
      .prt_in    (prt_prev),
      .az_in     (az_prev),
      .prt_out   (cell_prt[k]),
      .az_out    (cell_az[k]),
      .p0        (cell_prt[0]),
      .prt_tol   (prt_tol_r),
      .n_win     (n_win),
      .sel_a1    (sel_a1),
      .sel_a2    (sel_a2),
      .scan_en   (scan_en),
      .scan_load (scan_load),
      .scan_in   (scan_next),
      .scan_out  (cell_scan[k])
    );
  end

  rbft_scan_t scan0;
  assign scan0 = cell_scan[0];

  // Target quotient: floor((2*a1 + step) / (2*step))
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_quo;
  logic             div_done;
  logic             div_start;

  assign div_num   = NUM_W'({scan0.a1, 1'b0}) + NUM_W'(step);
  assign div_den   = {step, 1'b0};
  assign div_start = (state_r == S_DSTART);

  rbft_div #(
    .N_W (NUM_W),
    .D_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  logic [NUM_W+STEP_W-1:0] prod_full;
  assign prod_full = div_quo * step;

  // Beam decision
  logic a1_hi, a2_hi, straddle, zero_x, timeout, idx_ready, plain_ready;
  logic win_ok, beam;

  always_comb begin
    a1_hi    = ({1'b0, scan0.a1} + {1'b0, step}) > AZ_FULL;
    a2_hi    = ({1'b0, scan0.a2} + {1'b0, step}) > AZ_FULL;
    straddle = ((scan0.a1 <= tgt_r) && (scan0.a2 >= tgt_r)) ||
               ((scan0.a1 >= tgt_r) && (scan0.a2 <= tgt_r));
    zero_x  = (tgt_r == '0) &&
              ((a1_hi && (scan0.a2 < step)) || (a2_hi && (scan0.a1 < step)));
    timeout = (tgt_r != '0) && (since_r > {n_win, 4'b0000});
    idx_ready   = straddle || zero_x || timeout;
    plain_ready = (since_r >= SINCE_W'(n_win));
    win_ok  = (int'(seen_r) >= int'(n_win)) && (run_r >= n_win) && !scan0.bad;
    beam    = win_ok && (index_az_r ? idx_ready : plain_ready);
  end

  // Sequencer, counters and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_gate_r <= '0;
      run_r       <= '0;
      seen_r      <= '0;
      since_r     <= '0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Output register drain and load
      if (res_pend_r && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_ready_r <= res_ready_r;
        out_az_r    <= res_az_r;
        res_pend_r  <= 1'b0;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (int'(seen_r) < MAX_SAMPLES) begin
              seen_r <= seen_r + 1'b1;
            end
            if ((run_r != '0) && (in_gate == last_gate_r)) begin
              if (run_r < RUN_MAX) begin
                run_r <= run_r + 1'b1;
              end
            end else begin
              run_r <= RUN_W'(1);
            end
            last_gate_r <= in_gate;
            if (since_r < SINCE_MAX) begin
              since_r <= since_r + 1'b1;
            end
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          scan_cnt_r <= n_win - 1'b1;
          state_r    <= S_SCAN;
        end
        S_SCAN: begin
          scan_cnt_r <= scan_cnt_r - 1'b1;
          if (scan_cnt_r == NWIN_W'(1)) begin
            state_r <= S_DSTART;
          end
        end
        S_DSTART: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= prod_full[AZ_W:0];
          state_r <= S_WRAP;
        end
        S_WRAP: begin
          tgt_r   <= (prod_r >= AZ_FULL) ? AZ_W'(prod_r - AZ_FULL) : prod_r[AZ_W-1:0];
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          // Waits here while the previous result still occupies the slot
          if (!res_pend_r) begin
            res_ready_r <= beam;
            res_az_r    <= beam ? (index_az_r ? tgt_r : scan0.a1) : '0;
            res_pend_r  <= 1'b1;
            if (beam) begin
              since_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ready_r;
  assign out_tdata  = out_az_r;

endmodule
